// ===== hw/rtl/sf_pkg.sv =====
`default_nettype none
package sf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W  = 32;
  localparam int D_W    = POS_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int K_W    = 31;
  localparam int EMAG_W = ROOT_W;
  localparam int P_W    = K_W + EMAG_W;
  localparam int PLO_W  = 32 + D_W;
  localparam int PHI_W  = (P_W - 32) + D_W;
  localparam int NUM_W  = P_W + D_W;
  localparam int Q_W    = 33;

  localparam logic REG_K    = 1'b0;
  localparam logic REG_REST = 1'b1;

  localparam logic [K_W-1:0] K_RESET    = K_W'(65536);
  localparam logic [K_W-1:0] REST_RESET = K_W'(65536);

  typedef struct packed {
    logic [2:0][D_W-1:0] dmag;
    logic [2:0]          dneg;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] dneg;
    logic       eneg;
    logic       zero;
    logic [2:0] ovf;
  } dv_side_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] force_v;
    logic                  zero;
    logic                  sat;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sf_sqrt_cell.sv =====
`default_nettype none
module sf_sqrt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [sf_pkg::SUM_W-1:0]     rad_i,
  input  logic [sf_pkg::ROOT_W-1:0]    root_i,
  input  logic [sf_pkg::REM_W-1:0]     rem_i,
  input  sf_pkg::sq_side_t             side_i,
  output logic                         vld_o,
  output logic [sf_pkg::SUM_W-1:0]     rad_o,
  output logic [sf_pkg::ROOT_W-1:0]    root_o,
  output logic [sf_pkg::REM_W-1:0]     rem_o,
  output sf_pkg::sq_side_t             side_o
);
  import sf_pkg::*;

  logic [REM_W-1:0]  cur;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic              vld_q;
  logic [SUM_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  sq_side_t          side_q;

  always_comb begin
    cur   = {rem_i[REM_W-3:0], rad_i[SUM_W-1 -: 2]};
    trial = REM_W'({root_i, 2'b01});
    ge    = cur >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      root_q <= {root_i[ROOT_W-2:0], ge};
      rem_q  <= ge ? cur - trial : cur;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sf_div_cell.sv =====
`default_nettype none
module sf_div_cell #(
  parameter int DEN_W = sf_pkg::ROOT_W + sf_pkg::FRAC_BITS_DEF,
  parameter int SH    = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic [2:0][sf_pkg::NUM_W-1:0]        rem_i,
  input  logic [2:0][sf_pkg::Q_W-1:0]          q_i,
  input  logic [DEN_W-1:0]                     den_i,
  input  sf_pkg::dv_side_t                     side_i,
  output logic                                 vld_o,
  output logic [2:0][sf_pkg::NUM_W-1:0]        rem_o,
  output logic [2:0][sf_pkg::Q_W-1:0]          q_o,
  output logic [DEN_W-1:0]                     den_o,
  output sf_pkg::dv_side_t                     side_o
);
  import sf_pkg::*;

  logic [NUM_W-1:0]            sub;
  logic [2:0]                  ge;
  logic                        vld_q;
  logic [2:0][NUM_W-1:0]       rem_q;
  logic [2:0][Q_W-1:0]         q_q;
  logic [DEN_W-1:0]            den_q;
  dv_side_t                    side_q;

  always_comb begin
    sub = NUM_W'(den_i) << SH;
    for (int a = 0; a < 3; a++) begin
      ge[a] = rem_i[a] >= sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        rem_q[a] <= ge[a] ? rem_i[a] - sub : rem_i[a];
        q_q[a]   <= {q_i[a][Q_W-2:0], ge[a]};
      end
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== hw/rtl/spring_force.sv =====
`default_nettype none
// Hooke spring force on a particle from the spring's other end, signed Q16.16 in and out.
// Fully pipelined: one position pair is accepted per clock unless the chain is stalled,
// and each result passes through the 34 one-bit square root cells and then
// the 33 one-bit divider cells in the chain. A two-entry output stage (register plus
// skid) keeps the input side accepting while a result waits; when both hold a result
// the whole chain stalls. Spring constant sits at byte address 0 and rest length at 4;
// write them only while no transaction is in flight.
module spring_force #(
  parameter int FRAC_BITS = sf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic signed [31:0] other_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic        zero_length_o,
  output logic        saturated_o
);
  import sf_pkg::*;

  localparam int DEN_W = ROOT_W + FRAC_BITS;

  logic [K_W-1:0] k_q, rest_q;
  logic           adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= K_RESET;
      rest_q <= REST_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_K:    k_q    <= pwdata[K_W-1:0];
        REG_REST: rest_q <= pwdata[K_W-1:0];
        default:  k_q    <= k_q;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REST) ? 32'(rest_q) : 32'(k_q);

  // stage a: differences
  logic [2:0][POS_W-1:0] pin, oin;
  sq_side_t              a_side_d, a_side_q;
  logic                  a_vld_q;

  always_comb begin
    logic [D_W-1:0] d;
    pin = {pos_z_i, pos_y_i, pos_x_i};
    oin = {other_z_i, other_y_i, other_x_i};
    for (int a = 0; a < 3; a++) begin
      d = {pin[a][POS_W-1], pin[a]} - {oin[a][POS_W-1], oin[a]};
      a_side_d.dneg[a] = d[D_W-1];
      a_side_d.dmag[a] = d[D_W-1] ? -d : d;
    end
  end

  // stage b: squares, stage c: sum
  logic [2:0][SQ_W-1:0] b_sq_q;
  sq_side_t             b_side_q, c_side_q;
  logic                 b_vld_q, c_vld_q;
  logic [SUM_W-1:0]     c_sum_q;

  // square root chain
  logic [ROOT_W:0]                 sq_vld;
  logic [ROOT_W:0][SUM_W-1:0]      sq_rad;
  logic [ROOT_W:0][ROOT_W-1:0]     sq_root;
  logic [ROOT_W:0][REM_W-1:0]      sq_rem;
  sq_side_t [ROOT_W:0]             sq_side;

  assign sq_vld[0]  = c_vld_q;
  assign sq_rad[0]  = c_sum_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = c_side_q;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    sf_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (sq_vld[g]),
      .rad_i  (sq_rad[g]),
      .root_i (sq_root[g]),
      .rem_i  (sq_rem[g]),
      .side_i (sq_side[g]),
      .vld_o  (sq_vld[g+1]),
      .rad_o  (sq_rad[g+1]),
      .root_o (sq_root[g+1]),
      .rem_o  (sq_rem[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  // stage e: extension and denominator
  logic [ROOT_W:0]       ext;
  logic                  e_vld_q, e_eneg_q, e_zero_q;
  logic [EMAG_W-1:0]     e_emag_q;
  logic [DEN_W-1:0]      e_den_q;
  sq_side_t              e_side_q;

  assign ext = {1'b0, sq_root[ROOT_W]} - (ROOT_W+1)'(rest_q);

  // stage f: k times extension
  logic                  f_vld_q, f_eneg_q, f_zero_q;
  logic [P_W-1:0]        f_p_q;
  logic [DEN_W-1:0]      f_den_q;
  sq_side_t              f_side_q;

  // stage g: partial products
  logic                  g_vld_q, g_eneg_q, g_zero_q;
  logic [2:0][PLO_W-1:0] g_plo_q;
  logic [2:0][PHI_W-1:0] g_phi_q;
  logic [DEN_W-1:0]      g_den_q;
  logic [2:0]            g_dneg_q;

  // stage h: numerators
  logic                  h_vld_q, h_eneg_q, h_zero_q;
  logic [2:0][NUM_W-1:0] h_num_q;
  logic [DEN_W-1:0]      h_den_q;
  logic [2:0]            h_dneg_q;

  // stage i: overflow check
  logic                  i_vld_q;
  logic [2:0][NUM_W-1:0] i_num_q;
  logic [DEN_W-1:0]      i_den_q;
  dv_side_t              i_side_q;
  logic [2:0]            h_ovf;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      h_ovf[a] = h_num_q[a] >= (NUM_W'(h_den_q) << Q_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      e_vld_q <= sq_vld[ROOT_W];
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= a_side_d;
      for (int a = 0; a < 3; a++) begin
        b_sq_q[a] <= SQ_W'(a_side_q.dmag[a]) * SQ_W'(a_side_q.dmag[a]);
      end
      b_side_q <= a_side_q;
      c_sum_q  <= SUM_W'(b_sq_q[0]) + SUM_W'(b_sq_q[1]) + SUM_W'(b_sq_q[2]);
      c_side_q <= b_side_q;

      e_eneg_q <= ext[ROOT_W];
      e_emag_q <= ext[ROOT_W] ? EMAG_W'(-ext) : ext[EMAG_W-1:0];
      e_den_q  <= DEN_W'(sq_root[ROOT_W]) << FRAC_BITS;
      e_zero_q <= sq_root[ROOT_W] == '0;
      e_side_q <= sq_side[ROOT_W];

      f_p_q    <= P_W'(k_q) * P_W'(e_emag_q);
      f_eneg_q <= e_eneg_q;
      f_zero_q <= e_zero_q;
      f_den_q  <= e_den_q;
      f_side_q <= e_side_q;

      for (int a = 0; a < 3; a++) begin
        g_plo_q[a] <= PLO_W'(f_p_q[31:0]) * PLO_W'(f_side_q.dmag[a]);
        g_phi_q[a] <= PHI_W'(f_p_q[P_W-1:32]) * PHI_W'(f_side_q.dmag[a]);
      end
      g_eneg_q <= f_eneg_q;
      g_zero_q <= f_zero_q;
      g_den_q  <= f_den_q;
      g_dneg_q <= f_side_q.dneg;

      for (int a = 0; a < 3; a++) begin
        h_num_q[a] <= (NUM_W'(g_phi_q[a]) << 32) + NUM_W'(g_plo_q[a]);
      end
      h_eneg_q <= g_eneg_q;
      h_zero_q <= g_zero_q;
      h_den_q  <= g_den_q;
      h_dneg_q <= g_dneg_q;

      i_num_q       <= h_num_q;
      i_den_q       <= h_den_q;
      i_side_q.dneg <= h_dneg_q;
      i_side_q.eneg <= h_eneg_q;
      i_side_q.zero <= h_zero_q;
      i_side_q.ovf  <= h_ovf;
    end
  end

  // divider chain
  logic [Q_W:0]                    dv_vld;
  logic [Q_W:0][2:0][NUM_W-1:0]    dv_rem;
  logic [Q_W:0][2:0][Q_W-1:0]      dv_q;
  logic [Q_W:0][DEN_W-1:0]         dv_den;
  dv_side_t [Q_W:0]                dv_side;

  assign dv_vld[0]  = i_vld_q;
  assign dv_rem[0]  = i_num_q;
  assign dv_q[0]    = '0;
  assign dv_den[0]  = i_den_q;
  assign dv_side[0] = i_side_q;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    sf_div_cell #(
      .DEN_W (DEN_W),
      .SH    (Q_W - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dv_vld[g]),
      .rem_i  (dv_rem[g]),
      .q_i    (dv_q[g]),
      .den_i  (dv_den[g]),
      .side_i (dv_side[g]),
      .vld_o  (dv_vld[g+1]),
      .rem_o  (dv_rem[g+1]),
      .q_o    (dv_q[g+1]),
      .den_o  (dv_den[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // sign, saturation
  res_t fin;

  always_comb begin
    logic [Q_W-1:0] q;
    logic           ovf, neg, sat;
    fin.sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      q   = dv_q[Q_W][a];
      ovf = dv_side[Q_W].ovf[a];
      neg = (ovf || (q != '0)) && (dv_side[Q_W].eneg == dv_side[Q_W].dneg[a]);
      if (neg) begin
        sat = ovf || q[Q_W-1] || (q[31] && (q[30:0] != '0));
        fin.force_v[a] = sat ? 32'h8000_0000 : -q[31:0];
      end else begin
        sat = ovf || q[Q_W-1] || q[31];
        fin.force_v[a] = sat ? 32'h7fff_ffff : q[31:0];
      end
      fin.sat = fin.sat | sat;
    end
    fin.zero = dv_side[Q_W].zero;
    if (fin.zero) begin
      fin.force_v = '0;
      fin.sat     = 1'b0;
    end
  end

  // output register and skid
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d, out_free, pipe_vld;
  res_t out_q, out_d, skid_q;

  assign adv      = !skid_vld_q;
  assign pipe_vld = adv && dv_vld[Q_W];
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    if (out_free) begin
      out_vld_d  = skid_vld_q || pipe_vld;
      out_d      = skid_vld_q ? skid_q : fin;
      skid_vld_d = 1'b0;
    end else if (pipe_vld) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (!skid_vld_q) begin
      skid_q <= fin;
    end
  end

  assign in_ready_o    = adv;
  assign out_valid_o   = out_vld_q;
  assign force_x_o     = out_q.force_v[0];
  assign force_y_o     = out_q.force_v[1];
  assign force_z_o     = out_q.force_v[2];
  assign zero_length_o = out_q.zero;
  assign saturated_o   = out_q.sat;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid holds a result ahead of output");
  a_zero_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.zero) |-> (!out_q.sat && out_q.force_v == '0))
    else $error("zero length result not cleared");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(dv_q[Q_W]) || !skid_vld_q)
    else $error("chain moved while stalled");
`endif

endmodule
`default_nettype wire
